// ===== rtl/core/ess_pkg.sv =====
// Shared types, field widths, register indexes and limits of the environment
// sensor supervisor. No dependencies; compiled first.
package ess_pkg;

    // Default width of the millisecond time base.
    localparam int TIME_BITS_DEFAULT = 32;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_READ_PERIOD   = 2'd0,
        REG_RESCAN_PERIOD = 2'd1,
        REG_FAIL_LIMIT    = 2'd2
    } cfg_idx_t;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Field types.
    typedef logic        [31:0] now_ms_t;
    typedef logic signed [15:0] temp_in_t;
    typedef logic        [15:0] hum_in_t;
    typedef logic        [17:0] pres_in_t;
    typedef logic        [7:0]  light_byte_t;
    typedef logic signed [14:0] temp_out_t;
    typedef logic        [13:0] hum_out_t;
    typedef logic        [16:0] pres_out_t;
    typedef logic        [18:0] light_out_t;
    typedef logic        [15:0] period_t;
    typedef logic        [7:0]  fail_cnt_t;

    // Register reset values.
    localparam period_t   READ_PERIOD_RST   = 16'd2000;
    localparam period_t   RESCAN_PERIOD_RST = 16'd10000;
    localparam fail_cnt_t FAIL_LIMIT_RST    = 8'd3;
    localparam fail_cnt_t FAIL_SAT          = 8'd255;

    // Plausibility window of a climate reading.
    localparam temp_in_t TEMP_MIN = -16'sd4000;
    localparam temp_in_t TEMP_MAX = 16'sd8500;
    localparam hum_in_t  HUM_MAX  = 16'd10000;
    localparam pres_in_t PRES_MIN = 18'd30000;
    localparam pres_in_t PRES_MAX = 18'd120000;

    // Light decode: mantissa shifted by exponent, times nine half-lux units.
    localparam int LIGHT_MANT_BITS = 8;
    localparam int LIGHT_EXP_MAX   = 15;
    localparam int LIGHT_SHIFT_BITS = LIGHT_MANT_BITS + LIGHT_EXP_MAX;
    localparam int LIGHT_HALF_BITS  = LIGHT_SHIFT_BITS + 4;
    localparam logic [LIGHT_HALF_BITS-1:0] LIGHT_HALF_MAX = 27'd400000;

endpackage

// ===== rtl/core/ess_ifs.sv =====
// Handshake channels of the environment sensor supervisor: poll input,
// result output and configuration write. Depends on ess_pkg.
interface ess_poll_if;
    logic                   valid;
    logic                   ready;
    ess_pkg::now_ms_t       now_ms;
    logic                   climate_answers;
    logic                   light_answers;
    logic                   climate_read_ok;
    ess_pkg::temp_in_t      temp_centi;
    ess_pkg::hum_in_t       hum_centi;
    ess_pkg::pres_in_t      pressure_pa;
    logic                   light_read_ok;
    ess_pkg::light_byte_t   light_high_byte;
    ess_pkg::light_byte_t   light_low_byte;

    modport source (
        output valid, now_ms, climate_answers, light_answers, climate_read_ok,
               temp_centi, hum_centi, pressure_pa, light_read_ok,
               light_high_byte, light_low_byte,
        input  ready
    );
    modport sink (
        input  valid, now_ms, climate_answers, light_answers, climate_read_ok,
               temp_centi, hum_centi, pressure_pa, light_read_ok,
               light_high_byte, light_low_byte,
        output ready
    );
endinterface

interface ess_result_if;
    logic                   valid;
    logic                   ready;
    logic                   online;
    logic                   healthy;
    logic                   climate_valid;
    logic                   light_valid;
    ess_pkg::temp_out_t     temp_out;
    ess_pkg::hum_out_t      hum_out;
    ess_pkg::pres_out_t     pressure_out;
    ess_pkg::light_out_t    light_half_lux;

    modport source (
        output valid, online, healthy, climate_valid, light_valid, temp_out,
               hum_out, pressure_out, light_half_lux,
        input  ready
    );
    modport sink (
        input  valid, online, healthy, climate_valid, light_valid, temp_out,
               hum_out, pressure_out, light_half_lux,
        output ready
    );
endinterface

interface ess_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ess_pkg::CFG_IDX_BITS-1:0]    index;
    logic [ess_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/env_sensor_supervisor_unit.sv =====
// Environment sensor supervisor, top level and whole datapath.
// Depends on ess_pkg and the channel interfaces in ess_ifs.sv.
//
// One poll is taken every clock cycle when the result side keeps up. A poll
// first lands in an input register; when it moves on to the result slot, the
// scan/acquire decision, range checks, light decode and fail counters are
// evaluated in one pass and the state and result register are written
// together. poll.ready is high while the input register is empty or moves on
// this cycle, i.e. it follows result.ready combinationally when both
// registers hold an item. Config writes are always accepted (cfg.ready is
// tied high); write only while no poll is in flight. TIME_BITS sets the width
// of the internal time base: now_ms is truncated or zero-extended to it and
// elapsed time wraps at 2^TIME_BITS.
module env_sensor_supervisor_unit #(
    parameter int TIME_BITS = ess_pkg::TIME_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    ess_poll_if.sink      poll,
    ess_result_if.source  result,
    ess_cfg_if.sink       cfg
);

    typedef logic [TIME_BITS-1:0] tstamp_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    ess_pkg::period_t   read_period_reg;
    ess_pkg::period_t   rescan_period_reg;
    ess_pkg::fail_cnt_t fail_limit_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_period_reg   <= ess_pkg::READ_PERIOD_RST;
            rescan_period_reg <= ess_pkg::RESCAN_PERIOD_RST;
            fail_limit_reg    <= ess_pkg::FAIL_LIMIT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                ess_pkg::REG_READ_PERIOD:   read_period_reg   <= cfg.data;
                ess_pkg::REG_RESCAN_PERIOD: rescan_period_reg <= cfg.data;
                ess_pkg::REG_FAIL_LIMIT:    fail_limit_reg    <= cfg.data[7:0];
                default:                    ;  // unmapped index: drop
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic                 in_valid_reg;
    ess_pkg::now_ms_t     now_ms_reg;
    logic                 climate_answers_reg;
    logic                 light_answers_reg;
    logic                 climate_read_ok_reg;
    ess_pkg::temp_in_t    temp_centi_reg;
    ess_pkg::hum_in_t     hum_centi_reg;
    ess_pkg::pres_in_t    pressure_pa_reg;
    logic                 light_read_ok_reg;
    ess_pkg::light_byte_t light_high_reg;
    ess_pkg::light_byte_t light_low_reg;

    logic out_valid_reg;
    logic advance;

    // The poll in the input register moves on when the result slot is free
    // or being emptied this cycle.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            in_valid_reg <= poll.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            now_ms_reg          <= poll.now_ms;
            climate_answers_reg <= poll.climate_answers;
            light_answers_reg   <= poll.light_answers;
            climate_read_ok_reg <= poll.climate_read_ok;
            temp_centi_reg      <= poll.temp_centi;
            hum_centi_reg       <= poll.hum_centi;
            pressure_pa_reg     <= poll.pressure_pa;
            light_read_ok_reg   <= poll.light_read_ok;
            light_high_reg      <= poll.light_high_byte;
            light_low_reg       <= poll.light_low_byte;
        end
    end

    // ---------------------------------------------------------------
    // Supervisor state
    // ---------------------------------------------------------------
    logic                first_pending_reg, first_pending_next;
    logic                present_reg, present_next;
    logic                climate_online_reg, climate_online_next;
    logic                light_online_reg, light_online_next;
    ess_pkg::fail_cnt_t  climate_fails_reg, climate_fails_next;
    ess_pkg::fail_cnt_t  light_fails_reg, light_fails_next;
    logic                climate_ok_reg, climate_ok_next;
    logic                light_ok_reg, light_ok_next;
    ess_pkg::temp_out_t  temp_cache_reg, temp_cache_next;
    ess_pkg::hum_out_t   hum_cache_reg, hum_cache_next;
    ess_pkg::pres_out_t  pres_cache_reg, pres_cache_next;
    ess_pkg::light_out_t light_cache_reg, light_cache_next;
    tstamp_t             last_read_reg, last_read_next;
    tstamp_t             last_scan_reg, last_scan_next;

    // ---------------------------------------------------------------
    // Per-poll evaluation
    // ---------------------------------------------------------------
    tstamp_t now_t;
    logic    scan_due;
    logic    read_due;
    logic    climate_alive;
    logic    light_alive;
    logic    climate_good;
    logic    light_good;
    ess_pkg::fail_cnt_t climate_fails_bump;
    ess_pkg::fail_cnt_t light_fails_bump;

    logic [3:0]                                light_exp;
    logic [ess_pkg::LIGHT_MANT_BITS-1:0]       light_mant;
    logic [ess_pkg::LIGHT_SHIFT_BITS-1:0]      light_shifted;
    logic [ess_pkg::LIGHT_HALF_BITS-1:0]       light_half;

    assign now_t = TIME_BITS'(now_ms_reg);

    // Elapsed time wraps with the time base.
    assign scan_due = (tstamp_t'(now_t - last_scan_reg)) >= TIME_BITS'(rescan_period_reg);
    assign read_due = (tstamp_t'(now_t - last_read_reg)) >= TIME_BITS'(read_period_reg);

    assign climate_alive = climate_online_reg && climate_answers_reg;
    assign light_alive   = light_online_reg && light_answers_reg;

    assign climate_good = climate_read_ok_reg
                       && (temp_centi_reg >= ess_pkg::TEMP_MIN)
                       && (temp_centi_reg <= ess_pkg::TEMP_MAX)
                       && (hum_centi_reg <= ess_pkg::HUM_MAX)
                       && (pressure_pa_reg >= ess_pkg::PRES_MIN)
                       && (pressure_pa_reg <= ess_pkg::PRES_MAX);

    // Light: exponent in the high nibble, eight mantissa bits split across
    // both bytes; scale by nine as (x << 3) + x.
    assign light_exp     = light_high_reg[7:4];
    assign light_mant    = {light_high_reg[3:0], light_low_reg[7:4]};
    assign light_shifted = ess_pkg::LIGHT_SHIFT_BITS'(light_mant) << light_exp;
    assign light_half    = ess_pkg::LIGHT_HALF_BITS'({light_shifted, 3'b000})
                         + ess_pkg::LIGHT_HALF_BITS'(light_shifted);
    assign light_good    = light_read_ok_reg && (light_half <= ess_pkg::LIGHT_HALF_MAX);

    // Saturating fail counters.
    assign climate_fails_bump = (climate_fails_reg == ess_pkg::FAIL_SAT)
                              ? climate_fails_reg : climate_fails_reg + 8'd1;
    assign light_fails_bump   = (light_fails_reg == ess_pkg::FAIL_SAT)
                              ? light_fails_reg : light_fails_reg + 8'd1;

    always_comb
    begin
        first_pending_next  = first_pending_reg;
        present_next        = present_reg;
        climate_online_next = climate_online_reg;
        light_online_next   = light_online_reg;
        climate_fails_next  = climate_fails_reg;
        light_fails_next    = light_fails_reg;
        climate_ok_next     = climate_ok_reg;
        light_ok_next       = light_ok_reg;
        temp_cache_next     = temp_cache_reg;
        hum_cache_next      = hum_cache_reg;
        pres_cache_next     = pres_cache_reg;
        light_cache_next    = light_cache_reg;
        last_read_next      = last_read_reg;
        last_scan_next      = last_scan_reg;

        if (first_pending_reg)
        begin
            // First poll: scan now and back-date both timers so the next
            // poll rescans or acquires straight away.
            first_pending_next  = 1'b0;
            last_scan_next      = now_t - TIME_BITS'(rescan_period_reg);
            last_read_next      = now_t - TIME_BITS'(read_period_reg);
            climate_online_next = climate_answers_reg;
            light_online_next   = light_answers_reg;
            climate_fails_next  = '0;
            light_fails_next    = '0;
            present_next        = climate_answers_reg || light_answers_reg;
        end
        else if (!present_reg)
        begin
            if (scan_due)
            begin
                last_scan_next      = now_t;
                climate_online_next = climate_answers_reg;
                light_online_next   = light_answers_reg;
                climate_fails_next  = '0;
                light_fails_next    = '0;
                present_next        = climate_answers_reg || light_answers_reg;
            end
        end
        else if (read_due)
        begin
            last_read_next = now_t;
            if (!climate_alive && !light_alive)
            begin
                // Both sensors gone silent: drop offline and restart the
                // rescan timer.
                present_next    = 1'b0;
                climate_ok_next = 1'b0;
                light_ok_next   = 1'b0;
                last_scan_next  = now_t;
            end
            else
            begin
                if (climate_alive)
                begin
                    if (climate_good)
                    begin
                        temp_cache_next    = temp_centi_reg[14:0];
                        hum_cache_next     = hum_centi_reg[13:0];
                        pres_cache_next    = pressure_pa_reg[16:0];
                        climate_fails_next = '0;
                        climate_ok_next    = 1'b1;
                    end
                    else
                    begin
                        climate_fails_next = climate_fails_bump;
                        if (climate_fails_bump >= fail_limit_reg)
                        begin
                            climate_ok_next = 1'b0;
                        end
                    end
                end
                if (light_alive)
                begin
                    if (light_good)
                    begin
                        light_cache_next = light_half[18:0];
                        light_fails_next = '0;
                        light_ok_next    = 1'b1;
                    end
                    else
                    begin
                        light_fails_next = light_fails_bump;
                        if (light_fails_bump >= fail_limit_reg)
                        begin
                            light_ok_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Commit state only when the poll actually moves into the result slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pending_reg  <= 1'b1;
            present_reg        <= 1'b0;
            climate_online_reg <= 1'b0;
            light_online_reg   <= 1'b0;
            climate_fails_reg  <= '0;
            light_fails_reg    <= '0;
            climate_ok_reg     <= 1'b0;
            light_ok_reg       <= 1'b0;
            temp_cache_reg     <= '0;
            hum_cache_reg      <= '0;
            pres_cache_reg     <= '0;
            light_cache_reg    <= '0;
            last_read_reg      <= '0;
            last_scan_reg      <= '0;
        end
        else if (advance)
        begin
            first_pending_reg  <= first_pending_next;
            present_reg        <= present_next;
            climate_online_reg <= climate_online_next;
            light_online_reg   <= light_online_next;
            climate_fails_reg  <= climate_fails_next;
            light_fails_reg    <= light_fails_next;
            climate_ok_reg     <= climate_ok_next;
            light_ok_reg       <= light_ok_next;
            temp_cache_reg     <= temp_cache_next;
            hum_cache_reg      <= hum_cache_next;
            pres_cache_reg     <= pres_cache_next;
            light_cache_reg    <= light_cache_next;
            last_read_reg      <= last_read_next;
            last_scan_reg      <= last_scan_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic                online_reg;
    logic                healthy_reg;
    logic                climate_valid_reg;
    logic                light_valid_reg;
    ess_pkg::temp_out_t  temp_out_reg;
    ess_pkg::hum_out_t   hum_out_reg;
    ess_pkg::pres_out_t  pres_out_reg;
    ess_pkg::light_out_t light_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            online_reg        <= present_next;
            healthy_reg       <= present_next && (climate_fails_next < fail_limit_reg);
            climate_valid_reg <= climate_ok_next;
            light_valid_reg   <= light_ok_next;
            temp_out_reg      <= temp_cache_next;
            hum_out_reg       <= hum_cache_next;
            pres_out_reg      <= pres_cache_next;
            light_out_reg     <= light_cache_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.online         = online_reg;
    assign result.healthy        = healthy_reg;
    assign result.climate_valid  = climate_valid_reg;
    assign result.light_valid    = light_valid_reg;
    assign result.temp_out       = temp_out_reg;
    assign result.hum_out        = hum_out_reg;
    assign result.pressure_out   = pres_out_reg;
    assign result.light_half_lux = light_out_reg;

endmodule
